### design/e2i_pkg.sv
// Shared types, constants and escape tables for the EUC-JP to ISO-2022-JP converter.
// No dependencies; the front, queue, back and top-level files use it by scoped names.
`timescale 1ns / 1ps

package e2i_pkg;

   // Default number of plans held between the decoder and the byte emitter
   localparam int QUEUE_DEPTH = 2;

   // EUC-JP marker bytes
   localparam logic [7:0] SS2_BYTE  = 8'h8E;
   localparam logic [7:0] SS3_BYTE  = 8'h8F;
   localparam logic [7:0] HIGH_MARK = 8'hA0;
   localparam logic [6:0] ESC_BYTE  = 7'h1B;

   // Character sets of ISO-2022-JP
   typedef enum logic [1:0] {
      SET_ROMAN = 2'd0,
      SET_KANA  = 2'd1,
      SET_X0212 = 2'd2,
      SET_X0208 = 2'd3
   } set_type;

   // One output segment: optional escape into cs, then up to two character bytes
   typedef struct packed {
      logic        esc;
      set_type     cs;
      logic [1:0]  nbytes;
      logic [6:0]  b0;
      logic [6:0]  b1;
   } seg_type;

   // Work for one request: up to three characters plus a closing escape
   typedef struct packed {
      seg_type [3:0] seg;
      logic [1:0]    last_seg;
   } plan_type;

   // Length of the escape sequence that selects a set
   function automatic logic [2:0] esc_len(input set_type cs);
      logic [2:0] len;
      begin
         len = (cs == SET_X0212) ? 3'd4 : 3'd3;
         return len;
      end
   endfunction

   // Byte idx of the escape sequence that selects a set
   function automatic logic [6:0] esc_byte(input set_type cs, input logic [1:0] idx);
      logic [6:0] b;
      begin
         b = ESC_BYTE;
         case (cs)
            SET_ROMAN: begin
               case (idx)
                  2'd1:    b = 7'h28;
                  2'd2:    b = 7'h4A;
                  default: b = ESC_BYTE;
               endcase
            end
            SET_KANA: begin
               case (idx)
                  2'd1:    b = 7'h28;
                  2'd2:    b = 7'h49;
                  default: b = ESC_BYTE;
               endcase
            end
            SET_X0212: begin
               case (idx)
                  2'd1:    b = 7'h24;
                  2'd2:    b = 7'h28;
                  2'd3:    b = 7'h44;
                  default: b = ESC_BYTE;
               endcase
            end
            default: begin
               case (idx)
                  2'd1:    b = 7'h24;
                  2'd2:    b = 7'h42;
                  default: b = ESC_BYTE;
               endcase
            end
         endcase
         return b;
      end
   endfunction

endpackage

### design/e2i_front.sv
// Front end: accepts requests, decodes held bytes plus the new byte into a plan.
// Depends on e2i_pkg; owns the character-set mode and the held-byte registers.
`timescale 1ns / 1ps

module e2i_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_in_byte,
   input  logic               req_byte_valid,
   input  logic               req_end_of_block,
   input  logic               queue_full,
   output logic               push,
   output e2i_pkg::plan_type  plan
);

   e2i_pkg::set_type mode_ff, mode_in;
   logic [1:0]       pcnt_ff, pcnt_in;
   logic [7:0]       pend_ff [2];
   logic [7:0]       pend_in [2];

   logic [7:0]       q [4];
   logic [1:0]       n;
   logic [1:0]       p;
   logic [1:0]       left;
   logic [1:0]       adv;
   logic             stop;
   logic             have;
   logic [2:0]       nseg;
   logic [7:0]       b, t1, t2;
   e2i_pkg::set_type m;
   e2i_pkg::seg_type seg;
   logic             accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Gather held bytes and the new byte into one small window
   always_comb begin
      q[3] = 8'h00;
      case (pcnt_ff)
         2'd1: begin
            q[0] = pend_ff[0];
            q[1] = req_in_byte;
            q[2] = 8'h00;
         end
         2'd2: begin
            q[0] = pend_ff[0];
            q[1] = pend_ff[1];
            q[2] = req_in_byte;
         end
         default: begin
            q[0] = req_in_byte;
            q[1] = 8'h00;
            q[2] = 8'h00;
         end
      endcase
      n = pcnt_ff + {1'b0, req_byte_valid};
   end

   // Decode up to three characters, tracking the mode for escapes
   always_comb begin
      m    = mode_ff;
      p    = 2'd0;
      stop = 1'b0;
      nseg = 3'd0;
      plan = '0;
      seg  = '0;
      b    = 8'h00;
      t1   = 8'h00;
      t2   = 8'h00;
      left = 2'd0;
      adv  = 2'd0;
      have = 1'b0;
      for (int k = 0; k < 3; k++) begin
         have = 1'b0;
         seg  = '0;
         adv  = 2'd0;
         if (!stop && (p < n)) begin
            b    = q[p];
            t1   = q[p + 2'd1];
            t2   = q[p + 2'd2];
            left = n - p;
            if ((b < e2i_pkg::SS2_BYTE) || (b inside {[8'h90:8'h9F]})) begin
               have    = 1'b1;
               seg.cs  = e2i_pkg::SET_ROMAN;
               seg.nbytes = 2'd1;
               seg.b0  = b[6:0];
               adv     = 2'd1;
            end else if (b == e2i_pkg::SS2_BYTE) begin
               if (left >= 2'd2) begin
                  have    = 1'b1;
                  seg.cs  = e2i_pkg::SET_KANA;
                  seg.nbytes = 2'd1;
                  seg.b0  = t1[6:0];
                  adv     = 2'd2;
               end else begin
                  stop = 1'b1;
               end
            end else if (b == e2i_pkg::SS3_BYTE) begin
               if (left == 2'd3) begin
                  have = 1'b1;
                  if ((t1 <= e2i_pkg::HIGH_MARK) || (t2 <= e2i_pkg::HIGH_MARK)) begin
                     // bad trail: the lead goes out alone as Roman
                     seg.cs  = e2i_pkg::SET_ROMAN;
                     seg.nbytes = 2'd1;
                     seg.b0  = b[6:0];
                     adv     = 2'd1;
                  end else begin
                     seg.cs  = e2i_pkg::SET_X0212;
                     seg.nbytes = 2'd2;
                     seg.b0  = t1[6:0];
                     seg.b1  = t2[6:0];
                     adv     = 2'd3;
                  end
               end else begin
                  stop = 1'b1;
               end
            end else begin
               if (left >= 2'd2) begin
                  have = 1'b1;
                  if (t1 < e2i_pkg::HIGH_MARK) begin
                     seg.cs  = e2i_pkg::SET_ROMAN;
                     seg.nbytes = 2'd1;
                     seg.b0  = b[6:0];
                     adv     = 2'd1;
                  end else begin
                     seg.cs  = e2i_pkg::SET_X0208;
                     seg.nbytes = 2'd2;
                     seg.b0  = b[6:0];
                     seg.b1  = t1[6:0];
                     adv     = 2'd2;
                  end
               end else begin
                  stop = 1'b1;
               end
            end
            if (have) begin
               seg.esc = (seg.cs != m);
               plan.seg[nseg[1:0]] = seg;
               nseg = nseg + 3'd1;
               m    = seg.cs;
               p    = p + adv;
            end
         end
      end
      // Return to Roman at the end of a block
      if (req_end_of_block && (m != e2i_pkg::SET_ROMAN)) begin
         seg        = '0;
         seg.esc    = 1'b1;
         seg.cs     = e2i_pkg::SET_ROMAN;
         plan.seg[nseg[1:0]] = seg;
         nseg       = nseg + 3'd1;
         m          = e2i_pkg::SET_ROMAN;
      end
      plan.last_seg = 2'(nseg - 3'd1);
      mode_in    = m;
      pcnt_in    = n - p;
      pend_in[0] = q[p];
      pend_in[1] = q[p + 2'd1];
   end

   assign push = accept && (nseg != 3'd0);

   // Hold mode and count; advance on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= e2i_pkg::SET_ROMAN;
         pcnt_ff <= 2'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pcnt_ff <= pcnt_in;
      end
   end

   // Held bytes need no reset: only entries below the count are read
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff[0] <= pend_in[0];
         pend_ff[1] <= pend_in[1];
      end
   end

endmodule

### design/e2i_queue.sv
// Plan queue between the decoder and the byte emitter.
// Depends on e2i_pkg for the plan type; depth is a parameter of at least 1.
`timescale 1ns / 1ps

module e2i_queue #(
   parameter int DEPTH = e2i_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  e2i_pkg::plan_type  push_plan,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output e2i_pkg::plan_type  head_plan
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   e2i_pkg::plan_type entry_ff [DEPTH];
   logic [PW-1:0]     wr_ff, wr_in;
   logic [PW-1:0]     rd_ff, rd_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              do_pop;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_plan  = entry_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   // Advance pointers with wrap and track fill
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store plans
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_plan;
      end
   end

endmodule

### design/e2i_back.sv
// Back end: walks a plan one byte per cycle, unless stalled, into the response register.
// Depends on e2i_pkg for plan types and escape tables.
`timescale 1ns / 1ps

module e2i_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               plan_valid,
   input  e2i_pkg::plan_type  plan,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [6:0]         rsp_out_byte,
   output logic               rsp_run_last
);

   logic [1:0]       seg_ff, seg_in;
   logic [2:0]       pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [6:0]       rsp_byte_ff;
   logic             rsp_last_ff;

   e2i_pkg::seg_type cur;
   logic [2:0]       elen;
   logic [2:0]       len;
   logic [6:0]       nxt_byte;
   logic             seg_end;
   logic             plan_end;
   logic             load;

   // Pick the byte at the current position of the current segment
   always_comb begin
      cur  = plan.seg[seg_ff];
      elen = cur.esc ? e2i_pkg::esc_len(cur.cs) : 3'd0;
      len  = elen + {1'b0, cur.nbytes};
      if (pos_ff < elen) begin
         nxt_byte = e2i_pkg::esc_byte(cur.cs, pos_ff[1:0]);
      end else if (pos_ff == elen) begin
         nxt_byte = cur.b0;
      end else begin
         nxt_byte = cur.b1;
      end
      seg_end  = (pos_ff == (len - 3'd1));
      plan_end = seg_end && (seg_ff == plan.last_seg);
   end

   // Load the response register when it is empty or being taken
   assign load = plan_valid && (!rsp_valid_ff || rsp_ready);
   assign pop  = load && plan_end;

   always_comb begin
      seg_in       = seg_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in = 1'b1;
         if (plan_end) begin
            seg_in = 2'd0;
            pos_in = 3'd0;
         end else if (seg_end) begin
            seg_in = seg_ff + 2'd1;
            pos_in = 3'd0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= 2'd0;
         pos_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= nxt_byte;
         rsp_last_ff <= plan_end;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

### design/euc_jp_to_iso2022jp_converter.sv
// EUC-JP to ISO-2022-JP converter, top level.
// Depends on e2i_pkg, e2i_front, e2i_queue and e2i_back.
//
// Usage:
//   Request channel (req_*): one EUC-JP byte per request, with req_byte_valid
//   (0 means no byte, flush only) and req_end_of_block (return to Roman after
//   this byte, emitting ESC ( J when needed).
//   Response channel (rsp_*): one 7-bit ISO-2022-JP byte per response;
//   rsp_run_last marks the last byte caused by a request. A request that
//   completes no character and needs no closing escape produces no response at all.
//   The first byte of a request passes through the plan queue and the response
//   register. Throughput: one response byte per cycle while the receiver takes
//   them, set by the byte emitter; a request produces 0 to 12 bytes (typically
//   1 to 4). Requests are taken one per cycle while the plan queue
//   (QUEUE_DEPTH entries) has room.
//   Reset: mode returns to Roman, held bytes are dropped, queue is emptied.
//   When the receiver stalls, the response byte holds; the queue fills and
//   then req_ready drops.
`timescale 1ns / 1ps

module euc_jp_to_iso2022jp_converter #(
   parameter int QUEUE_DEPTH = e2i_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_block,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_out_byte,
   output logic        rsp_run_last
);

   e2i_pkg::plan_type push_plan;
   e2i_pkg::plan_type head_plan;
   logic              push;
   logic              pop;
   logic              full;
   logic              head_valid;

   // Decode and classify requests
   e2i_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .req_byte_valid   (req_byte_valid),
      .req_end_of_block (req_end_of_block),
      .queue_full       (full),
      .push             (push),
      .plan             (push_plan)
   );

   // Buffer plans between the two sides
   e2i_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_plan  (push_plan),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_plan  (head_plan)
   );

   // Emit bytes
   e2i_back u_back (
      .clock        (clock),
      .reset        (reset),
      .plan_valid   (head_valid),
      .plan         (head_plan),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

### design/e2i_checker.sv
// Port-level checks for the converter, bound to the top level.
// Depends only on the top level's port names.
`timescale 1ns / 1ps

module e2i_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [6:0]  rsp_out_byte,
   input logic        rsp_run_last
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last))
      else $error("response changed while stalled");

   // Drop responses after reset
   a_rsp_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Take requests right after reset: the plan queue starts empty
   a_ready_reset: assert property (@(posedge clock)
      !reset && $past(reset) |-> req_ready)
      else $error("request channel not ready right after reset");

   // Offer only known response bytes
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_out_byte, rsp_run_last}))
      else $error("response payload unknown while valid");

endmodule

bind euc_jp_to_iso2022jp_converter e2i_checker u_e2i_checker (.*);
